/* rtl/tapm_pkg.sv */
// Package for the two-axis PID move controller.
// Holds widths, register indexes, opcodes, status codes and the shared structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package tapm_pkg;

   // Encoder position and integral widths.
   localparam int POS_W  = 24;
   localparam int SUM_W  = 48;

   // Derived datapath widths.
   localparam int TGT_W  = 17;                 // signed move distance
   localparam int ERR_W  = POS_W + 2;          // goal and per-tick error
   localparam int DIFF_W = ERR_W + 1;          // error change for the D term
   localparam int AQ_W   = 32;                 // error magnitude, clamped to 2^31
   localparam int SQ_W   = 2 * AQ_W;           // squared error magnitude
   localparam int GAIN_W = 32;
   localparam int LIM_W  = 19;
   localparam int TOL_W  = 16;
   localparam int TSQ_W  = 2 * TOL_W;
   localparam int VEL_W  = 20;
   localparam int FRAC_W = 16;                 // Q32 sum down to Q16 output
   localparam int LO_W   = SUM_W / 2;          // integral split for the I product
   localparam int HI_W   = SUM_W - LO_W;
   localparam int ACC_W  = ((SUM_W > DIFF_W + 1) ? SUM_W : DIFF_W + 1) + 34;
   localparam int Q_W    = ACC_W - FRAC_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GAIN_W;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_FLOOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_P_RESET    = 32'd6442451;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET    = 32'd215;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET    = 32'd34359738;
   localparam logic [LIM_W-1:0]  VEL_LIMIT_RESET = 19'd65536;
   localparam logic [LIM_W-1:0]  VEL_FLOOR_RESET = 19'd0;
   localparam logic [TSQ_W-1:0]  TOL_SQ_RESET    = 32'd100;

   // Request opcodes; the unused code behaves as a cancel.
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   // Direction codes on a start.
   localparam logic [2:0] DIR_UP    = 3'd0;
   localparam logic [2:0] DIR_RIGHT = 3'd1;
   localparam logic [2:0] DIR_DOWN  = 3'd2;
   localparam logic [2:0] DIR_LEFT  = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_STARTED  = 3'd1,
      ST_RUNNING  = 3'd2,
      ST_ARRIVED  = 3'd3,
      ST_ABORTED  = 3'd4,
      ST_CANCELED = 3'd5
   } status_type;

   // Pipeline strobes shared by both lanes.
   typedef struct packed {
      logic accept;
      logic advance;
      logic commit;
   } lane_ctrl_type;

   // Outcome of one item as decided by the merge stage.
   typedef struct packed {
      logic       load_goal;
      logic       load_sum;
      logic       load_last;
      logic       run;
      logic       active;
      status_type status;
   } decide_type;

endpackage

`default_nettype wire

/* rtl/tapm_lane.sv */
// One axis lane of the PID move controller: error, integral, square and P+I+D.
// Holds the per-axis goal, integral and last error. Depends on tapm_pkg.
`default_nettype none

module tapm_lane
   import tapm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctrl_type            ctrl,
   input  decide_type               decide,
   input  logic signed [POS_W-1:0]  pos,
   input  logic signed [TGT_W-1:0]  target,
   input  logic [GAIN_W-1:0]        gain_p,
   input  logic [GAIN_W-1:0]        gain_i,
   input  logic [GAIN_W-1:0]        gain_d,
   input  logic [LIM_W-1:0]         vel_limit,
   input  logic [LIM_W-1:0]         vel_floor,
   output logic [SQ_W-1:0]          sq,
   output logic signed [VEL_W-1:0]  vel
);

   // Axis state. The goal is origin plus target, so one subtract gives the error.
   logic signed [ERR_W-1:0]  goal_ff, goal_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [ERR_W-1:0]  last_ff;

   // Front stages.
   logic signed [POS_W-1:0]  pos1_ff, pos2_ff, pos3_ff;
   logic signed [ERR_W-1:0]  err2_ff, err2_in;
   logic signed [ERR_W-1:0]  err3_ff;
   logic signed [SUM_W-1:0]  sum3_ff, sum3_in;
   logic signed [DIFF_W-1:0] diff3_ff, diff3_in;
   logic [SQ_W-1:0]          sq3_ff, sq3_in;

   // Product and accumulate stages.
   logic signed [GAIN_W+ERR_W:0]   pp4_ff, pp4_in;
   logic signed [GAIN_W+DIFF_W:0]  pd4_ff, pd4_in;
   logic [GAIN_W+LO_W-1:0]         pil4_ff, pil4_in;
   logic signed [GAIN_W+HI_W:0]    pih4_ff, pih4_in;
   logic signed [ACC_W-1:0]        a5_ff, a5_in, b5_ff, b5_in;
   logic signed [ACC_W-1:0]        w6_ff, w6_in;

   logic [ERR_W-1:0]         err_abs;
   logic [AQ_W-1:0]          err_mag;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [ACC_W-1:0]  pil_ext, pih_ext;
   logic signed [Q_W-1:0]    q_raw, q_lim, q_clamp;
   logic signed [VEL_W-1:0]  v_clamp, v_floor;

   always_comb begin
      err2_in = goal_ff - ERR_W'(pos1_ff);

      // Magnitude is clamped to 2^31 before squaring.
      err_abs = err2_ff[ERR_W-1] ? ERR_W'(-err2_ff) : err2_ff;
      if (64'(err_abs) > 64'h8000_0000) begin
         err_mag = 32'h8000_0000;
      end else begin
         err_mag = AQ_W'(err_abs);
      end
      sq3_in = SQ_W'(err_mag) * SQ_W'(err_mag);

      // Saturating integral update.
      sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(err2_ff);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum3_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum3_in = sum_wide[SUM_W-1:0];
      end
      diff3_in = DIFF_W'(err2_ff) - DIFF_W'(last_ff);

      goal_in = ERR_W'(pos3_ff) + ERR_W'(target);

      pp4_in  = $signed({1'b0, gain_p}) * err3_ff;
      pd4_in  = $signed({1'b0, gain_d}) * diff3_ff;
      pil4_in = gain_i * sum3_ff[LO_W-1:0];
      pih4_in = $signed({1'b0, gain_i}) * $signed(sum3_ff[SUM_W-1:LO_W]);

      pil_ext = ACC_W'(pil4_ff);
      pih_ext = ACC_W'(pih4_ff);
      a5_in   = ACC_W'(pp4_ff) + ACC_W'(pd4_ff);
      b5_in   = pil_ext + (pih_ext <<< LO_W);
      w6_in   = a5_ff + b5_ff;
   end

   // Q32 to Q16 by flooring, clamp to the limit, then raise to the floor.
   always_comb begin
      q_raw = w6_ff[ACC_W-1:FRAC_W];
      q_lim = Q_W'(vel_limit);
      if (q_raw > q_lim) begin
         q_clamp = q_lim;
      end else if (q_raw < -q_lim) begin
         q_clamp = -q_lim;
      end else begin
         q_clamp = q_raw;
      end
      v_clamp = q_clamp[VEL_W-1:0];
      v_floor = VEL_W'(vel_floor);
      if (v_clamp > 0 && v_clamp < v_floor) begin
         vel = v_floor;
      end else if (v_clamp < 0 && v_clamp > -v_floor) begin
         vel = -v_floor;
      end else begin
         vel = v_clamp;
      end
   end

   assign sq = sq3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff <= '0;
         sum_ff  <= '0;
         last_ff <= '0;
      end else if (ctrl.commit) begin
         if (decide.load_goal) begin
            goal_ff <= goal_in;
         end
         if (decide.load_sum) begin
            sum_ff <= sum3_ff;
         end
         if (decide.load_last) begin
            last_ff <= err3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         pos1_ff <= pos;
      end
      if (ctrl.advance) begin
         pos2_ff  <= pos1_ff;
         err2_ff  <= err2_in;
         pos3_ff  <= pos2_ff;
         err3_ff  <= err2_ff;
         sum3_ff  <= sum3_in;
         diff3_ff <= diff3_in;
         sq3_ff   <= sq3_in;
         pp4_ff   <= pp4_in;
         pd4_ff   <= pd4_in;
         pil4_ff  <= pil4_in;
         pih4_ff  <= pih4_in;
         a5_ff    <= a5_in;
         b5_ff    <= b5_in;
         w6_ff    <= w6_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tapm_merge.sv */
// Merge stage of the PID move controller: joins both lanes' squared errors
// into the arrival test and decides status and state updates. Depends on tapm_pkg.
`default_nettype none

module tapm_merge
   import tapm_pkg::*;
(
   input  logic [1:0]       opcode,
   input  logic [2:0]       direction,
   input  logic             active,
   input  logic [SQ_W-1:0]  sq_x,
   input  logic [SQ_W-1:0]  sq_y,
   input  logic [TSQ_W-1:0] tol_sq,
   output decide_type       decide
);

   logic [SQ_W-1:0] dist_sq;
   logic            arrived;

   always_comb begin
      dist_sq = sq_x + sq_y;
      arrived = dist_sq < SQ_W'(tol_sq);

      decide           = '0;
      decide.active    = active;
      decide.status    = ST_IDLE;
      case (opcode)
         OP_START: begin
            if (direction inside {[DIR_UP:DIR_LEFT]}) begin
               decide.load_goal = 1'b1;
               decide.active    = 1'b1;
               decide.status    = ST_STARTED;
            end else begin
               decide.active    = 1'b0;
               decide.status    = ST_ABORTED;
            end
         end
         OP_TICK: begin
            if (active) begin
               decide.load_sum = 1'b1;
               if (arrived) begin
                  decide.active = 1'b0;
                  decide.status = ST_ARRIVED;
               end else begin
                  decide.load_last = 1'b1;
                  decide.run       = 1'b1;
                  decide.status    = ST_RUNNING;
               end
            end
         end
         default: begin
            decide.active = 1'b0;
            decide.status = ST_CANCELED;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/two_axis_pid_move_controller.sv */
// Two-axis PID move controller. A request passes through the stage registers in turn, then
// the output register. A new request cannot enter until the previous one commits at the arrival
// decision (stage 3), since the axis state written there must be settled before the next request computes its error.
// Reset (synchronous, active high) clears the move, goal, integral and last error,
// loads the register defaults and empties the pipeline.
`default_nettype none

module two_axis_pid_move_controller
   import tapm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [2:0]                 req_direction,
   input  logic [15:0]                req_range_mm,
   input  logic signed [POS_W-1:0]    req_pos_x,
   input  logic signed [POS_W-1:0]    req_pos_y,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VEL_W-1:0]    rsp_vel_x,
   output logic signed [VEL_W-1:0]    rsp_vel_y,
   output logic [2:0]                 rsp_status,

   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers. The arrival tolerance is kept squared, since
   // the arrival test only ever compares against its square.
   logic [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [LIM_W-1:0]  vel_limit_ff, vel_floor_ff;
   logic [TSQ_W-1:0]  tol_sq_ff, tol_sq_in;

   // Pipeline occupancy. Stage 1 holds the accepted request, stage 2 the
   // errors, stage 3 the squares and integral (merge and commit), stages 4
   // to 6 the products and sums, then the output register.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rsp_valid_ff;
   logic move_active_ff;

   // Request fields that the merge stage needs at stage 3.
   logic [1:0]  op1_ff, op2_ff, op3_ff;
   logic [2:0]  dir1_ff, dir2_ff, dir3_ff;
   logic [15:0] range1_ff, range2_ff, range3_ff;

   // Outcome carried down to the output register.
   logic       run4_ff, run5_ff, run6_ff;
   status_type st4_ff, st5_ff, st6_ff;

   logic signed [VEL_W-1:0] rsp_vel_x_ff, rsp_vel_y_ff;
   status_type              rsp_status_ff;

   logic                    req_accept;
   logic                    advance;
   lane_ctrl_type           lane_ctrl;
   decide_type              decide;
   logic [SQ_W-1:0]         sq_x, sq_y;
   logic signed [VEL_W-1:0] vel_x, vel_y;
   logic signed [TGT_W-1:0] target_x, target_y, range_s;

   // The whole pipeline moves together; it holds only while a finished
   // result waits in the output register and the consumer stalls it.
   assign advance = !(rsp_valid_ff && rsp_stall);

   // Only one request may be between entry and its commit, because the
   // next request's error and integral depend on what that commit writes.
   // A request may enter at the same edge at which the previous one commits.
   assign req_stall  = v1_ff || v2_ff || (v3_ff && !advance);
   assign req_accept = req_valid && !req_stall;

   assign lane_ctrl.accept  = req_accept;
   assign lane_ctrl.advance = advance;
   assign lane_ctrl.commit  = v3_ff && advance;

   // Signed target per axis for a start: up is +y, right is -x, down is -y,
   // left is +x.
   always_comb begin
      range_s  = TGT_W'(range3_ff);
      target_x = '0;
      target_y = '0;
      case (dir3_ff)
         DIR_UP:    target_y = range_s;
         DIR_RIGHT: target_x = -range_s;
         DIR_DOWN:  target_y = -range_s;
         DIR_LEFT:  target_x = range_s;
         default: begin
            target_x = '0;
            target_y = '0;
         end
      endcase
   end

   assign tol_sq_in = TSQ_W'(csr_wdata[TOL_W-1:0]) * TSQ_W'(csr_wdata[TOL_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= GAIN_D_RESET;
         vel_limit_ff <= VEL_LIMIT_RESET;
         vel_floor_ff <= VEL_FLOOR_RESET;
         tol_sq_ff    <= TOL_SQ_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_GAIN_P:    gain_p_ff    <= csr_wdata;
            REG_GAIN_I:    gain_i_ff    <= csr_wdata;
            REG_GAIN_D:    gain_d_ff    <= csr_wdata;
            REG_VEL_LIMIT: vel_limit_ff <= csr_wdata[LIM_W-1:0];
            REG_VEL_FLOOR: vel_floor_ff <= csr_wdata[LIM_W-1:0];
            REG_TOLERANCE: tol_sq_ff    <= tol_sq_in;
            default: begin
               // Writes to indexes beyond the register list are dropped.
            end
         endcase
      end
   end

   // Pipeline control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
         v5_ff          <= 1'b0;
         v6_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         move_active_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            v1_ff <= 1'b1;
         end else if (advance) begin
            v1_ff <= 1'b0;
         end
         if (advance) begin
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            v4_ff        <= v3_ff;
            v5_ff        <= v4_ff;
            v6_ff        <= v5_ff;
            rsp_valid_ff <= v6_ff;
         end
         if (lane_ctrl.commit) begin
            move_active_ff <= decide.active;
         end
      end
   end

   // Payload registers; bubbles carry stale values that are never shown.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op1_ff    <= req_opcode;
         dir1_ff   <= req_direction;
         range1_ff <= req_range_mm;
      end
      if (advance) begin
         op2_ff    <= op1_ff;
         dir2_ff   <= dir1_ff;
         range2_ff <= range1_ff;
         op3_ff    <= op2_ff;
         dir3_ff   <= dir2_ff;
         range3_ff <= range2_ff;
         run4_ff   <= decide.run;
         st4_ff    <= decide.status;
         run5_ff   <= run4_ff;
         st5_ff    <= st4_ff;
         run6_ff   <= run5_ff;
         st6_ff    <= st5_ff;
         // Only a running tick shows the lanes' velocities; every other
         // outcome commands zero.
         rsp_vel_x_ff  <= run6_ff ? vel_x : '0;
         rsp_vel_y_ff  <= run6_ff ? vel_y : '0;
         rsp_status_ff <= st6_ff;
      end
   end

   tapm_lane u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .decide    (decide),
      .pos       (req_pos_x),
      .target    (target_x),
      .gain_p    (gain_p_ff),
      .gain_i    (gain_i_ff),
      .gain_d    (gain_d_ff),
      .vel_limit (vel_limit_ff),
      .vel_floor (vel_floor_ff),
      .sq        (sq_x),
      .vel       (vel_x)
   );

   tapm_lane u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .decide    (decide),
      .pos       (req_pos_y),
      .target    (target_y),
      .gain_p    (gain_p_ff),
      .gain_i    (gain_i_ff),
      .gain_d    (gain_d_ff),
      .vel_limit (vel_limit_ff),
      .vel_floor (vel_floor_ff),
      .sq        (sq_y),
      .vel       (vel_y)
   );

   // The merge stage sees both squared errors and decides the outcome that
   // the lanes commit.
   tapm_merge u_merge (
      .opcode    (op3_ff),
      .direction (dir3_ff),
      .active    (move_active_ff),
      .sq_x      (sq_x),
      .sq_y      (sq_y),
      .tol_sq    (tol_sq_ff),
      .decide    (decide)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vel_x  = rsp_vel_x_ff;
   assign rsp_vel_y  = rsp_vel_y_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   // At most one request sits in the front stages ahead of its commit.
   a_front_single: assert property (@(posedge clock) disable iff (reset)
      $countones({v1_ff, v2_ff, v3_ff}) <= 1)
      else $error("more than one request ahead of the commit stage");

   // Any outcome other than running commands zero velocity.
   a_zero_unless_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_RUNNING) |-> (rsp_vel_x == '0 && rsp_vel_y == '0))
      else $error("nonzero velocity on a result that is not running");

   // An arrival or a cancel ends the move.
   a_move_ends: assert property (@(posedge clock) disable iff (reset)
      (lane_ctrl.commit && (decide.status == ST_ARRIVED || decide.status == ST_CANCELED))
      |=> !move_active_ff)
      else $error("move still active after arrival or cancel");
`endif

endmodule

`default_nettype wire

/* tb/two_axis_pid_move_controller_tb.sv */
// Self-checking testbench for the two-axis PID move controller.
// It drives start, tick and cancel transfers with random idling, predicts each result with its
// own model of the controller and checks every field. Needs tapm_pkg and the controller RTL.

module two_axis_pid_move_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tapm_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 7;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int REPORT_MAX      = 10;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int POS_MAX         = 8388607;
   localparam int POS_MIN         = -8388608;

   // The fourth opcode has no name in the package; the controller treats it as a cancel.
   localparam logic [1:0]  OP_SPARE   = 2'd3;
   localparam logic [2:0]  DIR_BAD_LO = 3'd4;
   localparam logic [2:0]  DIR_BAD_HI = 3'd7;
   localparam logic [15:0] TOL_RESET  = 16'd10;

   typedef struct {
      logic [1:0]               opcode;
      logic [2:0]               direction;
      logic [15:0]              range_mm;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
   } move_req_type;

   typedef struct {
      logic signed [VEL_W-1:0]  vel_x;
      logic signed [VEL_W-1:0]  vel_y;
      status_type               status;
   } motion_rsp_type;

   // Every input of the controller has a known value from time zero.
   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_opcode    = '0;
   logic [2:0]                req_direction = '0;
   logic [15:0]               req_range_mm  = '0;
   logic signed [POS_W-1:0]   req_pos_x     = '0;
   logic signed [POS_W-1:0]   req_pos_y     = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic signed [VEL_W-1:0]   rsp_vel_x;
   logic signed [VEL_W-1:0]   rsp_vel_y;
   logic [2:0]                rsp_status;
   logic                      csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index     = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata     = '0;

   // Our copy of the register file, kept in step with every CSR write.
   logic [GAIN_W-1:0]  kp     = GAIN_P_RESET;
   logic [GAIN_W-1:0]  ki     = GAIN_I_RESET;
   logic [GAIN_W-1:0]  kd     = GAIN_D_RESET;
   logic [LIM_W-1:0]   vmax   = VEL_LIMIT_RESET;
   logic [LIM_W-1:0]   vmin   = VEL_FLOOR_RESET;
   logic [TOL_W-1:0]   tol_mm = TOL_RESET;

   // Our copy of the move state: goal, origin, integral and the error of the last running tick.
   logic    goal_active = 1'b0;
   longint  goal_tx     = 0;
   longint  goal_ty     = 0;
   longint  anchor_x    = 0;
   longint  anchor_y    = 0;
   longint  integ_x     = 0;
   longint  integ_y     = 0;
   longint  prev_err_x  = 0;
   longint  prev_err_y  = 0;

   move_req_type    pending_moves[$];
   motion_rsp_type  expected_motion[$];
   move_req_type    drive_item;
   move_req_type    seen_req;
   motion_rsp_type  want;

   int    mismatches     = 0;
   int    cycle_count    = 0;
   int    req_gap_odds   = 0;
   int    rsp_stall_odds = 0;
   int    req_gap_left   = 0;
   int    rsp_stall_left = 0;
   logic  req_taken      = 1'b0;

   two_axis_pid_move_controller i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_direction (req_direction),
      .req_range_mm  (req_range_mm),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_vel_x     (rsp_vel_x),
      .rsp_vel_y     (rsp_vel_y),
      .rsp_status    (rsp_status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   // The integral saturates at the signed bounds of the SUM_W-bit accumulator.
   function automatic longint clip_integral(longint acc, longint err);
      longint hi;
      longint lo;
      longint s;
      hi = (64'sd1 <<< (SUM_W - 1)) - 1;
      lo = -hi - 1;
      s  = acc + err;
      if (s > hi) s = hi;
      else if (s < lo) s = lo;
      return s;
   endfunction

   // One axis of P + I + D. The sum is exact in 128 bits and in Q32 m/s. It is floored
   // to Q16 by an arithmetic shift, clamped to the limit, and then the floor pushes a
   // small nonzero result out to the minimum magnitude. A sum too large for 64 bits
   // always clamps, so the shift-then-clamp order covers that case as well.
   function automatic logic signed [VEL_W-1:0] axis_velocity(longint err, longint integ,
                                                             longint prev);
      logic signed [127:0] gp, gi, gd, e, s, d, acc, q, lim, flo;
      gp  = {96'd0, kp};
      gi  = {96'd0, ki};
      gd  = {96'd0, kd};
      e   = 128'(err);
      s   = 128'(integ);
      d   = 128'(err - prev);
      acc = gp * e + gi * s + gd * d;
      q   = acc >>> FRAC_W;
      lim = {109'd0, vmax};
      flo = {109'd0, vmin};
      if (q > lim) q = lim;
      else if (q < -lim) q = -lim;
      if (q > 0 && q < flo) q = flo;
      else if (q < 0 && q > -flo) q = -flo;
      return q[VEL_W-1:0];
   endfunction

   // Expected result of one accepted request; updates our copy of the move state.
   function automatic motion_rsp_type motion_outcome(move_req_type m);
      motion_rsp_type r;
      longint px, py, ex, ey, rng, tol_sq;
      r.vel_x  = '0;
      r.vel_y  = '0;
      r.status = ST_IDLE;
      px  = longint'(m.pos_x);
      py  = longint'(m.pos_y);
      rng = longint'(m.range_mm);
      case (m.opcode)
         OP_START: begin
            if (m.direction <= DIR_LEFT) begin
               goal_tx = (m.direction == DIR_RIGHT) ? -rng : (m.direction == DIR_LEFT) ? rng : 0;
               goal_ty = (m.direction == DIR_DOWN) ? -rng : (m.direction == DIR_UP) ? rng : 0;
               anchor_x    = px;
               anchor_y    = py;
               goal_active = 1'b1;
               r.status    = ST_STARTED;
            end else begin
               // A bad direction drops the move but keeps the old goal and origin.
               goal_active = 1'b0;
               r.status    = ST_ABORTED;
            end
         end
         OP_TICK: begin
            if (goal_active) begin
               ex = goal_tx - (px - anchor_x);
               ey = goal_ty - (py - anchor_y);
               integ_x = clip_integral(integ_x, ex);
               integ_y = clip_integral(integ_y, ey);
               tol_sq  = longint'(tol_mm) * longint'(tol_mm);
               if (ex * ex + ey * ey < tol_sq) begin
                  // Arrival still feeds the integral but leaves the last error alone.
                  goal_active = 1'b0;
                  r.status    = ST_ARRIVED;
               end else begin
                  r.vel_x    = axis_velocity(ex, integ_x, prev_err_x);
                  r.vel_y    = axis_velocity(ey, integ_y, prev_err_y);
                  prev_err_x = ex;
                  prev_err_y = ey;
                  r.status   = ST_RUNNING;
               end
            end
         end
         default: begin
            // Cancel and the spare opcode both end any move, even when idle.
            goal_active = 1'b0;
            r.status    = ST_CANCELED;
         end
      endcase
      return r;
   endfunction

   function automatic int rand_pos();
      logic signed [POS_W-1:0] p;
      p = POS_W'($urandom);
      return int'(p);
   endfunction

   task automatic queue_item(logic [1:0] op, logic [2:0] dir, logic [15:0] rng, int px, int py);
      move_req_type m;
      m.opcode    = op;
      m.direction = dir;
      m.range_mm  = rng;
      m.pos_x     = px[POS_W-1:0];
      m.pos_y     = py[POS_W-1:0];
      pending_moves.push_back(m);
   endtask

   // A well-formed move: a start, then ticks whose position walks toward the goal with some
   // noise. The last tick usually lands close enough to arrive. Now and then the move is
   // cut short by a cancel or the spare opcode. Fields that a tick ignores carry random bits.
   task automatic queue_move();
      logic [2:0]  dir;
      logic [15:0] rng;
      int ox, oy, r, tx, ty, n, noise, px, py;
      dir = 3'($urandom_range(DIR_UP, DIR_LEFT));
      rng = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
      if ($urandom_range(0, 3) == 0) begin
         ox = rand_pos();
         oy = rand_pos();
      end else begin
         ox = int'($urandom_range(0, 20000)) - 10000;
         oy = int'($urandom_range(0, 20000)) - 10000;
      end
      r  = int'(rng);
      tx = (dir == DIR_LEFT) ? r : (dir == DIR_RIGHT) ? -r : 0;
      ty = (dir == DIR_UP) ? r : (dir == DIR_DOWN) ? -r : 0;
      queue_item(OP_START, dir, rng, ox, oy);
      n = $urandom_range(1, 10);
      for (int k = 1; k <= n; k++) begin
         if ($urandom_range(0, 24) == 0) begin
            queue_item($urandom_range(0, 1) ? OP_CANCEL : OP_SPARE, 3'($urandom),
                       16'($urandom), rand_pos(), rand_pos());
            return;
         end
         noise = (k == n && $urandom_range(0, 2) != 0) ? 3 : 40;
         px = ox + tx * k / n + int'($urandom_range(0, 2 * noise)) - noise;
         py = oy + ty * k / n + int'($urandom_range(0, 2 * noise)) - noise;
         queue_item(OP_TICK, 3'($urandom), 16'($urandom), px, py);
      end
   endtask

   // Registers are only written with the controller idle; our copy follows at once.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_GAIN_P:    kp     = value;
         REG_GAIN_I:    ki     = value;
         REG_GAIN_D:    kd     = value;
         REG_VEL_LIMIT: vmax   = value[LIM_W-1:0];
         REG_VEL_FLOOR: vmin   = value[LIM_W-1:0];
         REG_TOLERANCE: tol_mm = value[TOL_W-1:0];
         default: ;
      endcase
   endtask

   // Idle means every queued request has been transferred and every result has come back.
   // A short pause follows so that nothing is left in flight inside the pipeline.
   task automatic wait_for_idle();
      while (pending_moves.size() != 0 || req_valid || expected_motion.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Request driver. A new item goes out at the falling edge after the previous transfer,
   // or after a gap. Gaps come in bursts and are chosen without looking at
   // req_stall, and a stalled item is held unchanged until it transfers.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_gap_left = req_gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_moves.size() == 0) begin
            req_valid <= 1'b0;
         end else if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
            req_gap_left = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else begin
            drive_item = pending_moves.pop_front();
            req_opcode    <= drive_item.opcode;
            req_direction <= drive_item.direction;
            req_range_mm  <= drive_item.range_mm;
            req_pos_x     <= drive_item.pos_x;
            req_pos_y     <= drive_item.pos_y;
            req_valid     <= 1'b1;
         end
      end
   end

   // Result back-pressure, also in bursts.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
         rsp_stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor. Results are checked before this edge's request is predicted, so a stray result
   // can never take the expectation of the request that transfers at the same edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_motion.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected result vel_x %0d vel_y %0d status %0d",
                        $time, rsp_vel_x, rsp_vel_y, rsp_status);
         end else begin
            want = expected_motion.pop_front();
            if (rsp_vel_x !== want.vel_x || rsp_vel_y !== want.vel_y ||
                rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: expected vel_x %0d vel_y %0d status %0d, got %0d %0d %0d",
                           $time, want.vel_x, want.vel_y, want.status,
                           rsp_vel_x, rsp_vel_y, rsp_status);
            end
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         seen_req.opcode    = req_opcode;
         seen_req.direction = req_direction;
         seen_req.range_mm  = req_range_mm;
         seen_req.pos_x     = req_pos_x;
         seen_req.pos_y     = req_pos_y;
         expected_motion.push_back(motion_outcome(seen_req));
      end
   end

   // Watchdog on a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus: reset, a directed pass with the register defaults, then random phases that each
   // start from a fresh register setting. The last phase runs without any idling.
   initial begin
      logic [GAIN_W-1:0] new_kp, new_ki, new_kd;
      logic [LIM_W-1:0]  new_vmax, new_vmin;
      logic [TOL_W-1:0]  new_tol;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      req_gap_odds   = 4;
      rsp_stall_odds = 4;
      // Opcodes with no move in progress, and bad directions at the position extremes.
      queue_item(OP_TICK, DIR_UP, 16'd0, 0, 0);
      queue_item(OP_CANCEL, DIR_UP, 16'd0, 0, 0);
      queue_item(OP_SPARE, DIR_BAD_HI, 16'hFFFF, POS_MAX, POS_MIN);
      queue_item(OP_START, DIR_BAD_LO, 16'hFFFF, POS_MAX, POS_MIN);
      queue_item(OP_START, DIR_BAD_HI, 16'd0, POS_MIN, POS_MAX);
      // A zero-length move arrives on its first tick; the next tick finds the controller idle.
      queue_item(OP_START, DIR_UP, 16'd0, POS_MAX, POS_MIN);
      queue_item(OP_TICK, DIR_UP, 16'd0, POS_MAX, POS_MIN);
      queue_item(OP_TICK, DIR_UP, 16'd0, POS_MAX, POS_MIN);
      // The longest move with the encoder jumping end to end: both axes clamp, then the
      // derivative term swings the other way.
      queue_item(OP_START, DIR_LEFT, 16'hFFFF, POS_MAX, POS_MAX);
      queue_item(OP_TICK, DIR_BAD_HI, 16'hFFFF, POS_MIN, POS_MIN);
      queue_item(OP_TICK, DIR_UP, 16'd0, POS_MAX, POS_MAX);
      queue_item(OP_CANCEL, DIR_UP, 16'd0, 0, 0);
      // Negative errors, then an arrival inside the tolerance radius.
      queue_item(OP_START, DIR_RIGHT, 16'd300, 0, 0);
      queue_item(OP_TICK, DIR_UP, 16'd0, -100, 5);
      queue_item(OP_TICK, DIR_UP, 16'd0, -295, 0);
      // Cancel in the middle of a move; the following tick is ignored.
      queue_item(OP_START, DIR_DOWN, 16'd1000, POS_MIN, POS_MAX);
      queue_item(OP_TICK, DIR_UP, 16'd0, POS_MIN, POS_MAX - 500);
      queue_item(OP_CANCEL, DIR_UP, 16'd0, 0, 0);
      queue_item(OP_TICK, DIR_UP, 16'd0, POS_MIN, POS_MAX - 1000);
      // An error exactly on the tolerance radius keeps running; one millimetre less arrives.
      queue_item(OP_START, DIR_UP, 16'd10, 0, 0);
      queue_item(OP_TICK, DIR_UP, 16'd0, 0, 0);
      queue_item(OP_START, DIR_UP, 16'd9, 0, 0);
      queue_item(OP_TICK, DIR_UP, 16'd0, 0, 0);
      // The spare opcode cancels a move.
      queue_item(OP_START, DIR_LEFT, 16'd50, 0, 0);
      queue_item(OP_SPARE, DIR_UP, 16'd0, 0, 0);

      for (int phase = 1; phase < PHASES; phase++) begin
         wait_for_idle();
         case (phase)
            1: begin
               new_kp = $urandom_range(0, 50000000);
               new_ki = $urandom_range(0, 100000);
               new_kd = $urandom_range(0, 100000000);
               new_vmax = LIM_W'($urandom_range(1000, 262144));
               new_vmin = LIM_W'($urandom_range(0, 2000));
               new_tol  = TOL_W'($urandom_range(0, 300));
               req_gap_odds   = 4;
               rsp_stall_odds = 4;
            end
            2: begin
               // Largest gains and no arrival possible: every running tick saturates.
               new_kp = '1;
               new_ki = '1;
               new_kd = '1;
               new_vmax = LIM_W'(262144);
               new_vmin = '0;
               new_tol  = '0;
               req_gap_odds   = 0;
               rsp_stall_odds = 5;
            end
            3: begin
               // Zero gains and a zero limit; the widest tolerance makes most ticks arrive.
               new_kp = '0;
               new_ki = '0;
               new_kd = '0;
               new_vmax = '0;
               new_vmin = '0;
               new_tol  = '1;
               req_gap_odds   = 6;
               rsp_stall_odds = 0;
            end
            4: begin
               // Floor above the limit: the floor wins on any nonzero result.
               new_kp = $urandom;
               new_ki = $urandom;
               new_kd = $urandom;
               new_vmax = LIM_W'(100);
               new_vmin = '1;
               new_tol  = TOL_W'($urandom_range(0, 50));
               req_gap_odds   = 3;
               rsp_stall_odds = 3;
            end
            5: begin
               new_kp = $urandom;
               new_ki = '0;
               new_kd = $urandom;
               new_vmax = '1;
               new_vmin = LIM_W'(262144);
               new_tol  = TOL_W'($urandom_range(0, 1000));
               req_gap_odds   = 0;
               rsp_stall_odds = 0;
            end
            6: begin
               new_kp = $urandom;
               new_ki = $urandom_range(0, 1000000);
               new_kd = $urandom;
               new_vmax = LIM_W'($urandom);
               new_vmin = LIM_W'($urandom_range(0, 5000));
               new_tol  = TOL_W'($urandom_range(0, 2000));
               req_gap_odds   = 8;
               rsp_stall_odds = 2;
            end
            default: begin
               // Back to the reset defaults for the final stretch, with no idling at all.
               new_kp = GAIN_P_RESET;
               new_ki = GAIN_I_RESET;
               new_kd = GAIN_D_RESET;
               new_vmax = VEL_LIMIT_RESET;
               new_vmin = VEL_FLOOR_RESET;
               new_tol  = TOL_RESET;
               req_gap_odds   = 0;
               rsp_stall_odds = 0;
            end
         endcase
         write_register(REG_GAIN_P, new_kp);
         write_register(REG_GAIN_I, new_ki);
         write_register(REG_GAIN_D, new_kd);
         write_register(REG_VEL_LIMIT, CSR_DATA_W'(new_vmax));
         write_register(REG_VEL_FLOOR, CSR_DATA_W'(new_vmin));
         write_register(REG_TOLERANCE, CSR_DATA_W'(new_tol));

         // Mostly well-formed moves, with some fully random requests mixed in.
         while (pending_moves.size() < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 4) != 0)
               queue_move();
            else
               queue_item(2'($urandom), 3'($urandom), 16'($urandom), rand_pos(), rand_pos());
         end
      end

      wait_for_idle();
      mismatches += expected_motion.size();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
